// ----- sv/ssoi_pkg.sv -----
// ----------------------------------------------------------------------------
// ssoi_pkg
// Shared constants, request codes and helpers for the skid-steer odometry
// integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssoi_pkg;

   localparam int REQ_DATA_W = 368;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 192;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [1:0] REQ_WHEEL = 2'd0;
   localparam logic [1:0] REQ_HOME  = 2'd1;
   localparam logic [1:0] REQ_JUMP  = 2'd2;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_GEAR   = 2'd1;
   localparam logic [1:0] CSR_TRACK  = 2'd2;
   localparam logic [1:0] CSR_RADIUS = 2'd3;

   localparam logic [7:0]  GEAR_RST   = 8'd38;
   localparam logic [19:0] TRACK_RST  = 20'd68157;
   localparam logic [15:0] RADIUS_RST = 16'd10322;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;

   localparam int WHEEL_K     = 28110495;
   localparam int TWO_PI_Q16  = 411775;
   localparam int PI_Q16      = 205887;
   localparam int HALF_PI_Q16 = 102944;
   localparam int CORDIC_GAIN = 652032874;
   localparam int US_PER_TICK = 15625;

   // arctangent of 2^-i in Q2.30
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:    r = 30'd843314857;
         5'd1:    r = 30'd497837829;
         5'd2:    r = 30'd263043837;
         5'd3:    r = 30'd133525159;
         5'd4:    r = 30'd67021687;
         5'd5:    r = 30'd33543516;
         5'd6:    r = 30'd16775851;
         5'd7:    r = 30'd8388437;
         5'd8:    r = 30'd4194283;
         5'd9:    r = 30'd2097149;
         5'd10:   r = 30'd1048576;
         5'd11:   r = 30'd524288;
         5'd12:   r = 30'd262144;
         5'd13:   r = 30'd131072;
         5'd14:   r = 30'd65536;
         5'd15:   r = 30'd32768;
         5'd16:   r = 30'd16384;
         5'd17:   r = 30'd8192;
         5'd18:   r = 30'd4096;
         5'd19:   r = 30'd2048;
         5'd20:   r = 30'd1024;
         5'd21:   r = 30'd512;
         5'd22:   r = 30'd256;
         5'd23:   r = 30'd128;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   // {clipped, value}
   function automatic logic [32:0] sat32(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      logic [63:0] r;
      r = v[63] ? 64'(-v) : 64'(v);
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/skid_steer_odometry_integrator.sv -----
// ----------------------------------------------------------------------------
// skid_steer_odometry_integrator
// Skid-steer wheel odometry in Q16.16: wheel speeds, time step, Euler or
// midpoint pose update and CORDIC sin/cos on one shared multiply/divide unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | req_tdata, req_tuser
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
//  A wheel sample runs as a sequence of calls to the radix-2 divider and the
//  radix-16 multiplier, with one more CORDIC pass in midpoint mode than in
//  Euler mode. Reset pose and teleport requests go straight to the response
//  state. req_tready is high only while idle; a new request may be taken
//  while a response is still held. Synchronous reset restores the register
//  defaults and clears pose and motion.
// ----------------------------------------------------------------------------
`default_nettype none

module skid_steer_odometry_integrator #(
   parameter int CORDIC_STEPS = ssoi_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // rpm_front_left, rpm_front_right, rpm_rear_left, rpm_rear_right,
   // stamp_front_left, stamp_front_right, stamp_rear_left, stamp_rear_right,
   // jump_x, jump_y, jump_heading
   input  wire logic [ssoi_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire logic [ssoi_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // pose_x, pose_y, pose_heading, speed_x, speed_y, turn_rate
   output logic [ssoi_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // saturated
   output logic [ssoi_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ssoi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssoi_pkg::CSR_DATA_W-1:0] csr_data
);

   import ssoi_pkg::*;

   localparam int CORDIC_N  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int MUL_STEPS = 8;
   localparam int DIV_STEPS = 64;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_MUL    = 5'd1;
   localparam logic [4:0] ST_DIV    = 5'd2;
   localparam logic [4:0] ST_W_SRL  = 5'd3;
   localparam logic [4:0] ST_W_KL   = 5'd4;
   localparam logic [4:0] ST_W_DL   = 5'd5;
   localparam logic [4:0] ST_W_VL   = 5'd6;
   localparam logic [4:0] ST_W_KR   = 5'd7;
   localparam logic [4:0] ST_W_DR   = 5'd8;
   localparam logic [4:0] ST_W_VR   = 5'd9;
   localparam logic [4:0] ST_W_LIN  = 5'd10;
   localparam logic [4:0] ST_W_OM   = 5'd11;
   localparam logic [4:0] ST_W_DT   = 5'd12;
   localparam logic [4:0] ST_E_X    = 5'd13;
   localparam logic [4:0] ST_E_XA   = 5'd14;
   localparam logic [4:0] ST_E_YA   = 5'd15;
   localparam logic [4:0] ST_R_MID  = 5'd16;
   localparam logic [4:0] ST_R_STEP = 5'd17;
   localparam logic [4:0] ST_R_CS   = 5'd18;
   localparam logic [4:0] ST_R_X    = 5'd19;
   localparam logic [4:0] ST_R_XA   = 5'd20;
   localparam logic [4:0] ST_R_YA   = 5'd21;
   localparam logic [4:0] ST_H      = 5'd22;
   localparam logic [4:0] ST_H_A    = 5'd23;
   localparam logic [4:0] ST_H_CS   = 5'd24;
   localparam logic [4:0] ST_C_RED  = 5'd25;
   localparam logic [4:0] ST_C_IT   = 5'd26;
   localparam logic [4:0] ST_C_FIN  = 5'd27;
   localparam logic [4:0] ST_V_X    = 5'd28;
   localparam logic [4:0] ST_V_XA   = 5'd29;
   localparam logic [4:0] ST_V_YA   = 5'd30;
   localparam logic [4:0] ST_DONE   = 5'd31;

   logic [4:0] state_ff, state_in, ret_ff, ret_in, cret_ff, cret_in;
   logic [5:0] cnt_ff, cnt_in;

   logic        mode_ff, mode_in;
   logic [7:0]  gear_ff, gear_in;
   logic [19:0] track_ff, track_in;
   logic [15:0] radius_ff, radius_in;

   logic signed [20:0] s_left_ff, s_left_in, s_right_ff, s_right_in;
   logic [47:0]        avg_ff, avg_in;

   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0] heading_ff, heading_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0] omega_ff, omega_in, last_lin_ff, last_lin_in;
   logic [47:0]        last_stamp_ff, last_stamp_in;

   logic signed [31:0] vl_ff, vl_in, vr_ff, vr_in, lin_ff, lin_in;
   logic signed [31:0] om_ff, om_in, dt_ff, dt_in;
   logic signed [47:0] step_ff, step_in;
   logic signed [63:0] t_ff, t_in;
   logic signed [17:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               cneg_ff, cneg_in;
   logic               sat_ff, sat_in;

   logic [63:0] mul_a_ff, mul_a_in, mul_acc_ff, mul_acc_in;
   logic [31:0] mul_b_ff, mul_b_in;
   logic        mul_neg_ff, mul_neg_in;
   logic [63:0] div_q_ff, div_q_in;
   logic [40:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic                mul_go, div_go;
   logic signed [63:0]  mul_opa;
   logic signed [32:0]  mul_opb;
   logic [63:0]         div_num;
   logic [40:0]         div_den;

   logic signed [63:0] mul_res, rq16, rq17;
   logic [63:0]        mag16, mag17;
   logic [7:0]         gear_eff;
   logic [19:0]        track_eff;
   logic signed [32:0] vsum, vdiff;
   logic signed [48:0] dus;
   logic signed [63:0] qpos;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   assign mul_res   = mul_neg_ff ? -$signed(mul_acc_ff) : $signed(mul_acc_ff);
   assign mag16     = (mul_acc_ff + 64'd32768) >> 16;
   assign mag17     = (mul_acc_ff + 64'd65536) >> 17;
   assign rq16      = mul_neg_ff ? -$signed(mag16) : $signed(mag16);
   assign rq17      = mul_neg_ff ? -$signed(mag17) : $signed(mag17);
   assign gear_eff  = (gear_ff == 8'd0) ? 8'd1 : gear_ff;
   assign track_eff = (track_ff == 20'd0) ? 20'd1 : track_ff;
   assign vsum      = 33'(vl_ff) + 33'(vr_ff);
   assign vdiff     = 33'(vr_ff) - 33'(vl_ff);
   assign dus       = $signed({1'b0, avg_ff}) - $signed({1'b0, last_stamp_ff});
   assign qpos      = $signed(div_q_ff);

   always_comb begin
      logic [32:0]        sv;
      logic [63:0]        part;
      logic [41:0]        sh;
      logic [32:0]        m33;
      logic [31:0]        lmag;
      logic [18:0]        rem;
      logic signed [20:0] r1;
      logic signed [33:0] xs, ys, at, fx, fy;

      state_in = state_ff;  ret_in = ret_ff;  cret_in = cret_ff;  cnt_in = cnt_ff;
      mode_in = mode_ff;  gear_in = gear_ff;  track_in = track_ff;  radius_in = radius_ff;
      s_left_in = s_left_ff;  s_right_in = s_right_ff;  avg_in = avg_ff;
      pos_x_in = pos_x_ff;  pos_y_in = pos_y_ff;  heading_in = heading_ff;
      vel_x_in = vel_x_ff;  vel_y_in = vel_y_ff;  omega_in = omega_ff;
      last_lin_in = last_lin_ff;  last_stamp_in = last_stamp_ff;
      vl_in = vl_ff;  vr_in = vr_ff;  lin_in = lin_ff;  om_in = om_ff;  dt_in = dt_ff;
      step_in = step_ff;  t_in = t_ff;  cos_in = cos_ff;  sin_in = sin_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  cneg_in = cneg_ff;  sat_in = sat_ff;
      mul_a_in = mul_a_ff;  mul_b_in = mul_b_ff;  mul_acc_in = mul_acc_ff;
      mul_neg_in = mul_neg_ff;
      div_q_in = div_q_ff;  div_rem_in = div_rem_ff;  div_den_in = div_den_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;  rsp_sat_in = rsp_sat_ff;
      mul_go = 1'b0;  mul_opa = '0;  mul_opb = '0;
      div_go = 1'b0;  div_num = '0;  div_den = '0;
      sv = '0;  part = '0;  sh = '0;  m33 = '0;  lmag = '0;  rem = '0;  r1 = '0;
      xs = '0;  ys = '0;  at = '0;  fx = '0;  fy = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:   mode_in = csr_data[0];
            CSR_GEAR:   gear_in = csr_data[7:0];
            CSR_TRACK:  track_in = csr_data[19:0];
            CSR_RADIUS: radius_in = csr_data[15:0];
            default:    mode_in = mode_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sat_in = 1'b0;
               case (req_tuser)
                  REQ_WHEEL: begin
                     s_left_in  = 21'($signed(req_tdata[19:0])) +
                                  21'($signed(req_tdata[59:40]));
                     s_right_in = 21'($signed(req_tdata[39:20])) +
                                  21'($signed(req_tdata[79:60]));
                     avg_in = 48'(({2'b0, req_tdata[127:80]} + {2'b0, req_tdata[175:128]}
                            + {2'b0, req_tdata[223:176]} + {2'b0, req_tdata[271:224]}) >> 2);
                     state_in = ST_W_SRL;
                  end
                  REQ_HOME: begin
                     pos_x_in = '0;  pos_y_in = '0;  heading_in = '0;
                     vel_x_in = '0;  vel_y_in = '0;  omega_in = '0;
                     last_lin_in = '0;  last_stamp_in = '0;
                     state_in = ST_DONE;
                  end
                  REQ_JUMP: begin
                     pos_x_in = $signed(req_tdata[303:272]);
                     pos_y_in = $signed(req_tdata[335:304]);
                     heading_in = $signed(req_tdata[367:336]);
                     vel_x_in = '0;  vel_y_in = '0;  omega_in = '0;
                     last_lin_in = '0;  last_stamp_in = '0;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL: begin
            part = (mul_b_ff[0] ? mul_a_ff : 64'd0) + (mul_b_ff[1] ? mul_a_ff << 1 : 64'd0)
                 + (mul_b_ff[2] ? mul_a_ff << 2 : 64'd0) + (mul_b_ff[3] ? mul_a_ff << 3 : 64'd0);
            mul_acc_in = mul_acc_ff + part;
            mul_a_in = mul_a_ff << 4;
            mul_b_in = mul_b_ff >> 4;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_STEPS - 1)) begin
               state_in = ret_ff;
            end
         end
         ST_DIV: begin
            sh = {div_rem_ff, div_q_ff[63]};
            if (sh >= {1'b0, div_den_ff}) begin
               div_rem_in = 41'(sh - {1'b0, div_den_ff});
               div_q_in = {div_q_ff[62:0], 1'b1};
            end else begin
               div_rem_in = sh[40:0];
               div_q_in = {div_q_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ret_ff;
            end
         end
         ST_W_SRL: begin
            mul_go = 1'b1;  mul_opa = 64'(s_left_ff);  mul_opb = $signed({17'd0, radius_ff});
            state_in = ST_W_KL;
         end
         ST_W_KL: begin
            mul_go = 1'b1;  mul_opa = mul_res;  mul_opb = 33'(WHEEL_K);
            state_in = ST_W_DL;
         end
         ST_W_DL: begin
            div_go = 1'b1;
            div_num = mul_acc_ff + {24'd0, gear_eff, 32'd0};
            div_den = {gear_eff, 33'd0};
            state_in = ST_W_VL;
         end
         ST_W_VL: begin
            vl_in = mul_neg_ff ? $signed(div_q_ff[31:0]) : -$signed(div_q_ff[31:0]);
            mul_go = 1'b1;  mul_opa = 64'(s_right_ff);  mul_opb = $signed({17'd0, radius_ff});
            state_in = ST_W_KR;
         end
         ST_W_KR: begin
            mul_go = 1'b1;  mul_opa = mul_res;  mul_opb = 33'(WHEEL_K);
            state_in = ST_W_DR;
         end
         ST_W_DR: begin
            div_go = 1'b1;
            div_num = mul_acc_ff + {24'd0, gear_eff, 32'd0};
            div_den = {gear_eff, 33'd0};
            state_in = ST_W_VR;
         end
         ST_W_VR: begin
            vr_in = mul_neg_ff ? -$signed(div_q_ff[31:0]) : $signed(div_q_ff[31:0]);
            state_in = ST_W_LIN;
         end
         ST_W_LIN: begin
            m33 = vsum[32] ? 33'(-vsum) : 33'(vsum);
            lmag = 32'((m33 + 33'd1) >> 1);
            lin_in = vsum[32] ? -$signed(lmag) : $signed(lmag);
            m33 = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
            div_go = 1'b1;
            div_num = {15'd0, m33, 16'd0} + {45'd0, track_eff[19:1]};
            div_den = {21'd0, track_eff};
            state_in = ST_W_OM;
         end
         ST_W_OM: begin
            sv = sat32(vdiff[32] ? -qpos : qpos);
            om_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            div_go = 1'b1;
            div_num = {6'd0, 48'(dus[48] ? -dus : dus), 10'd0};
            div_den = 41'(US_PER_TICK);
            state_in = ST_W_DT;
         end
         ST_W_DT: begin
            sv = sat32(dus[48] ? -qpos : qpos);
            dt_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            state_in = mode_ff ? ST_R_MID : ST_E_X;
         end
         ST_E_X: begin
            mul_go = 1'b1;  mul_opa = 64'(vel_x_ff);  mul_opb = 33'(dt_ff);
            state_in = ST_E_XA;
         end
         ST_E_XA: begin
            sv = sat32(64'(pos_x_ff) + rq16);
            pos_x_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            mul_go = 1'b1;  mul_opa = 64'(vel_y_ff);  mul_opb = 33'(dt_ff);
            state_in = ST_E_YA;
         end
         ST_E_YA: begin
            sv = sat32(64'(pos_y_ff) + rq16);
            pos_y_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            state_in = ST_H;
         end
         ST_R_MID: begin
            mul_go = 1'b1;  mul_opa = 64'(omega_ff);  mul_opb = 33'(dt_ff);
            state_in = ST_R_STEP;
         end
         ST_R_STEP: begin
            t_in = 64'(heading_ff) + rq17;
            mul_go = 1'b1;  mul_opa = 64'(last_lin_ff);  mul_opb = 33'(dt_ff);
            state_in = ST_R_CS;
         end
         ST_R_CS: begin
            step_in = rq16[47:0];
            div_go = 1'b1;  div_num = mag64(t_ff);  div_den = 41'(TWO_PI_Q16);
            cret_in = ST_R_X;
            state_in = ST_C_RED;
         end
         ST_R_X: begin
            mul_go = 1'b1;  mul_opa = 64'(step_ff);  mul_opb = 33'(cos_ff);
            state_in = ST_R_XA;
         end
         ST_R_XA: begin
            sv = sat32(64'(pos_x_ff) + rq16);
            pos_x_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            mul_go = 1'b1;  mul_opa = 64'(step_ff);  mul_opb = 33'(sin_ff);
            state_in = ST_R_YA;
         end
         ST_R_YA: begin
            sv = sat32(64'(pos_y_ff) + rq16);
            pos_y_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            state_in = ST_H;
         end
         ST_H: begin
            mul_go = 1'b1;  mul_opa = 64'(omega_ff);  mul_opb = 33'(dt_ff);
            state_in = ST_H_A;
         end
         ST_H_A: begin
            sv = sat32(64'(heading_ff) + rq16);
            heading_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            state_in = ST_H_CS;
         end
         ST_H_CS: begin
            t_in = 64'(heading_ff);
            div_go = 1'b1;  div_num = mag64(64'(heading_ff));  div_den = 41'(TWO_PI_Q16);
            cret_in = ST_V_X;
            state_in = ST_C_RED;
         end
         ST_C_RED: begin
            // floor modulo 2*pi, then fold into +-pi/2
            rem = div_rem_ff[18:0];
            if (t_ff[63] && (rem != 19'd0)) begin
               r1 = 21'(TWO_PI_Q16) - $signed({2'b0, rem});
            end else begin
               r1 = $signed({2'b0, rem});
            end
            if (r1 > 21'(PI_Q16)) begin
               r1 = r1 - 21'(TWO_PI_Q16);
            end
            cneg_in = 1'b0;
            if (r1 > 21'(HALF_PI_Q16)) begin
               r1 = r1 - 21'(PI_Q16);
               cneg_in = 1'b1;
            end else if (r1 < -21'(HALF_PI_Q16)) begin
               r1 = r1 + 21'(PI_Q16);
               cneg_in = 1'b1;
            end
            cz_in = 34'(r1) <<< 14;
            cx_in = 34'(CORDIC_GAIN);
            cy_in = '0;
            cnt_in = '0;
            state_in = ST_C_IT;
         end
         ST_C_IT: begin
            xs = cx_ff >>> cnt_ff[4:0];
            ys = cy_ff >>> cnt_ff[4:0];
            at = $signed({4'd0, atan_q30(cnt_ff[4:0])});
            if (!cz_ff[33]) begin
               cx_in = cx_ff - ys;  cy_in = cy_ff + xs;  cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;  cy_in = cy_ff - xs;  cz_in = cz_ff + at;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CORDIC_N - 1)) begin
               state_in = ST_C_FIN;
            end
         end
         ST_C_FIN: begin
            fx = (cx_ff + 34'sd8192) >>> 14;
            fy = (cy_ff + 34'sd8192) >>> 14;
            cos_in = cneg_ff ? -fx[17:0] : fx[17:0];
            sin_in = cneg_ff ? -fy[17:0] : fy[17:0];
            state_in = cret_ff;
         end
         ST_V_X: begin
            mul_go = 1'b1;  mul_opa = 64'(lin_ff);  mul_opb = 33'(cos_ff);
            state_in = ST_V_XA;
         end
         ST_V_XA: begin
            sv = sat32(rq16);
            vel_x_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            mul_go = 1'b1;  mul_opa = 64'(lin_ff);  mul_opb = 33'(sin_ff);
            state_in = ST_V_YA;
         end
         ST_V_YA: begin
            sv = sat32(rq16);
            vel_y_in = $signed(sv[31:0]);
            sat_in = sat_ff | sv[32];
            omega_in = om_ff;
            last_lin_in = lin_ff;
            last_stamp_in = avg_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {omega_ff, vel_y_ff, vel_x_ff, heading_ff, pos_y_ff, pos_x_ff};
               rsp_sat_in = sat_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (mul_go) begin
         ret_in = state_in;
         state_in = ST_MUL;
         mul_a_in = mag64(mul_opa);
         mul_b_in = mul_opb[32] ? 32'(-mul_opb) : mul_opb[31:0];
         mul_neg_in = mul_opa[63] ^ mul_opb[32];
         mul_acc_in = '0;
         cnt_in = '0;
      end
      if (div_go) begin
         ret_in = state_in;
         state_in = ST_DIV;
         div_q_in = div_num;
         div_den_in = div_den;
         div_rem_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff <= 1'b0;
         gear_ff <= GEAR_RST;
         track_ff <= TRACK_RST;
         radius_ff <= RADIUS_RST;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         heading_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         omega_ff <= '0;
         last_lin_ff <= '0;
         last_stamp_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff <= mode_in;
         gear_ff <= gear_in;
         track_ff <= track_in;
         radius_ff <= radius_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         heading_ff <= heading_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         omega_ff <= omega_in;
         last_lin_ff <= last_lin_in;
         last_stamp_ff <= last_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      cret_ff <= cret_in;
      s_left_ff <= s_left_in;
      s_right_ff <= s_right_in;
      avg_ff <= avg_in;
      vl_ff <= vl_in;
      vr_ff <= vr_in;
      lin_ff <= lin_in;
      om_ff <= om_in;
      dt_ff <= dt_in;
      step_ff <= step_in;
      t_ff <= t_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      cneg_ff <= cneg_in;
      sat_ff <= sat_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      mul_acc_ff <= mul_acc_in;
      mul_neg_ff <= mul_neg_in;
      div_q_ff <= div_q_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request ready while busy");

   a_wheel_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == REQ_WHEEL)) |=> (state_ff == ST_W_SRL))
      else $error("wheel sample did not start");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done");

   a_cordic_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_IT) |-> (cnt_ff < 6'(CORDIC_N)))
      else $error("cordic step count overrun");

endmodule

`default_nettype wire

// ----- tb/sv/skid_steer_odometry_integrator_tb.sv -----
// ----------------------------------------------------------------------------
// skid_steer_odometry_integrator_tb
// Drives wheel, reset pose, teleport and unused-code requests through the request stream,
// predicts every pose and velocity response with a local Q16.16 odometry
// model, and checks the responses field by field under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module skid_steer_odometry_integrator_tb;
   import ssoi_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int         WATCHDOG_LIMIT = 20000;
   localparam int         DRAIN_CYCLES = 600;
   localparam int         RANDOM_PER_PHASE = 215;

   localparam longint ATAN_Q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   typedef struct {
      logic [1:0]         kind;
      logic signed [19:0] rpm [4];
      logic [47:0]        stamp [4];
      logic signed [31:0] jx, jy, jh;
   } odo_req_t;

   typedef struct {
      logic signed [31:0] px, py, ph, vx, vy, om;
      logic               sat;
   } odo_pose_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   skid_steer_odometry_integrator uut (.*);

   always #5 clock = ~clock;

   odo_req_t  pending_reqs [$];
   odo_pose_t expected_poses [$];
   odo_req_t  cur_req;
   int        tx_idle = 0, rx_idle = 0;
   bit        failed = 1'b0;
   int        quiet_cycles = 0;
   longint    wheel_time = 0;

   // predictor state
   logic       mode_q = 1'b0;
   logic [7:0] gear_q = GEAR_RST;
   logic [19:0] track_q = TRACK_RST;
   logic [15:0] radius_q = RADIUS_RST;
   int     pos_x, pos_y, head, vel_x, vel_y, omega, lin_last;
   longint unsigned stamp_last;
   bit     clipped;

   function automatic longint rdiv(input longint num, input longint unsigned den);
      longint unsigned m, q;
      m = num < 0 ? longint'(-num) : num;
      q = (m + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) begin
         clipped = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint mulq(input longint a, input longint b);
      return rdiv(a * b, 65536);
   endfunction

   function automatic void sin_cos(input longint angle, output longint c, output longint s);
      longint r, x, y, z, nx, xs, ys;
      bit     flip;
      r = angle % TWO_PI_Q16;
      flip = 1'b0;
      if (r < 0) r += TWO_PI_Q16;
      if (r > PI_Q16) r -= TWO_PI_Q16;
      if (r > HALF_PI_Q16) begin
         r -= PI_Q16;
         flip = 1'b1;
      end else if (r < -HALF_PI_Q16) begin
         r += PI_Q16;
         flip = 1'b1;
      end
      z = r * 16384;
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            nx = x - ys;
            y = y + xs;
            z -= ATAN_Q30[i];
         end else begin
            nx = x + ys;
            y = y - xs;
            z += ATAN_Q30[i];
         end
         x = nx;
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic void clear_motion();
      vel_x = 0;
      vel_y = 0;
      omega = 0;
      lin_last = 0;
      stamp_last = 0;
   endfunction

   function automatic void integrate_wheels(input odo_req_t it);
      longint unsigned g, tw, den, avg;
      longint sl, sr, vl, vr, lin, om, dus, dt, mid, stp, c, s;
      g = gear_q != 0 ? gear_q : 1;
      tw = track_q != 0 ? track_q : 1;
      den = g << 33;
      sl = longint'(it.rpm[0]) + longint'(it.rpm[2]);
      sr = longint'(it.rpm[1]) + longint'(it.rpm[3]);
      vl = -rdiv(sl * longint'(radius_q) * WHEEL_K, den);
      vr = rdiv(sr * longint'(radius_q) * WHEEL_K, den);
      lin = clip32(rdiv(vl + vr, 2));
      om = clip32(rdiv((vr - vl) * 65536, tw));
      avg = (longint'(it.stamp[0]) + it.stamp[1] + it.stamp[2] + it.stamp[3]) / 4;
      dus = longint'(avg) - longint'(stamp_last);
      dt = clip32((dus * 1024) / US_PER_TICK);
      stamp_last = avg;
      if (!mode_q) begin
         pos_x = clip32(longint'(pos_x) + mulq(vel_x, dt));
         pos_y = clip32(longint'(pos_y) + mulq(vel_y, dt));
      end else begin
         mid = longint'(head) + rdiv(longint'(omega) * dt, 131072);
         stp = mulq(lin_last, dt);
         sin_cos(mid, c, s);
         pos_x = clip32(longint'(pos_x) + mulq(stp, c));
         pos_y = clip32(longint'(pos_y) + mulq(stp, s));
      end
      head = clip32(longint'(head) + mulq(omega, dt));
      sin_cos(head, c, s);
      vel_x = clip32(mulq(lin, c));
      vel_y = clip32(mulq(lin, s));
      omega = om;
      lin_last = lin;
   endfunction

   function automatic void predict_pose(input odo_req_t it);
      odo_pose_t e;
      clipped = 1'b0;
      case (it.kind)
         REQ_WHEEL: integrate_wheels(it);
         REQ_HOME: begin
            pos_x = 0;
            pos_y = 0;
            head = 0;
            clear_motion();
         end
         REQ_JUMP: begin
            pos_x = it.jx;
            pos_y = it.jy;
            head = it.jh;
            clear_motion();
         end
         default: ;
      endcase
      e.px = pos_x;
      e.py = pos_y;
      e.ph = head;
      e.vx = vel_x;
      e.vy = vel_y;
      e.om = omega;
      e.sat = clipped;
      expected_poses.push_back(e);
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(input odo_req_t it);
      return {it.jh, it.jy, it.jx, it.stamp[3], it.stamp[2], it.stamp[1], it.stamp[0],
              it.rpm[3], it.rpm[2], it.rpm[1], it.rpm[0]};
   endfunction

   function automatic void check_field(input string name, input longint exp_v,
                                       input longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         failed = 1'b1;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_pose(cur_req);
         if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= pack_req(cur_req);
            req_tuser <= cur_req.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      odo_pose_t e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_poses.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               e = expected_poses.pop_front();
               check_field("pose_x", e.px, $signed(rsp_tdata[31:0]));
               check_field("pose_y", e.py, $signed(rsp_tdata[63:32]));
               check_field("pose_heading", e.ph, $signed(rsp_tdata[95:64]));
               check_field("speed_x", e.vx, $signed(rsp_tdata[127:96]));
               check_field("speed_y", e.vy, $signed(rsp_tdata[159:128]));
               check_field("turn_rate", e.om, $signed(rsp_tdata[191:160]));
               check_field("saturated", e.sat, rsp_tuser[0]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [19:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:  mode_q = val[0];
         CSR_GEAR:  gear_q = val[7:0];
         CSR_TRACK: track_q = val;
         default:   radius_q = val[15:0];
      endcase
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_poses.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic odo_req_t wheel_req(input int rpm_span, input longint dt_us);
      odo_req_t it;
      it.kind = REQ_WHEEL;
      wheel_time += dt_us;
      if (wheel_time < 0) wheel_time = 0;
      for (int k = 0; k < 4; k++) begin
         it.rpm[k] = 20'($signed($urandom_range(2 * rpm_span)) - rpm_span);
         it.stamp[k] = 48'(wheel_time + $urandom_range(300));
      end
      it.jx = $urandom;
      it.jy = $urandom;
      it.jh = $urandom;
      return it;
   endfunction

   function automatic odo_req_t noise_req();
      odo_req_t it;
      it.kind = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
         it.rpm[k] = $urandom;
         it.stamp[k] = {$urandom, $urandom};
      end
      it.jx = $urandom;
      it.jy = $urandom;
      it.jh = $urandom;
      return it;
   endfunction

   function automatic odo_req_t jump_req();
      odo_req_t it;
      it = noise_req();
      it.kind = REQ_JUMP;
      if ($urandom_range(1)) begin
         it.jx = $signed($urandom_range(4000000)) - 2000000;
         it.jy = $signed($urandom_range(4000000)) - 2000000;
         it.jh = $signed($urandom_range(2000000)) - 1000000;
      end
      wheel_time = 0;
      return it;
   endfunction

   task automatic load_directed();
      odo_req_t it;
      it = noise_req();
      it.kind = REQ_HOME;
      pending_reqs.push_back(it);
      it = jump_req();
      it.jx = 32'h7FFF_FFFF;
      it.jy = 32'h8000_0000;
      it.jh = 32'h7FFF_FFFF;
      pending_reqs.push_back(it);
      it = wheel_req(0, 20000);
      it.rpm = '{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF};
      pending_reqs.push_back(it);
      it = wheel_req(0, 20000);
      it.rpm = '{20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000};
      pending_reqs.push_back(it);
      it = wheel_req(0, 20000);
      it.rpm = '{20'sh80000, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF};
      pending_reqs.push_back(it);
      it = jump_req();
      it.jx = 32'h8000_0000;
      it.jy = 32'h7FFF_FFFF;
      it.jh = 32'h8000_0000;
      pending_reqs.push_back(it);
      for (int n = 0; n < 4; n++) pending_reqs.push_back(wheel_req(60000, 30000));
      // time running backwards, then a tiny step
      pending_reqs.push_back(wheel_req(60000, -50000));
      pending_reqs.push_back(wheel_req(60000, 1));
      it = noise_req();
      it.kind = REQ_UNUSED;
      pending_reqs.push_back(it);
      it = wheel_req(60000, 0);
      it.stamp = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                   48'hFFFF_FFFF_FFFF};
      pending_reqs.push_back(it);
      it.stamp = '{48'd0, 48'd0, 48'd0, 48'd0};
      pending_reqs.push_back(it);
      wheel_time = 0;
      for (int n = 0; n < 3; n++) pending_reqs.push_back(wheel_req(80000, 10000));
   endtask

   task automatic load_random();
      int pick;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         pick = $urandom_range(99);
         if (pick < 82) begin
            pending_reqs.push_back(wheel_req($urandom_range(1) ? 90000 : 524287,
                                             $urandom_range(1000, 60000)));
         end else if (pick < 86) begin
            pending_reqs.push_back(wheel_req(90000, -longint'($urandom_range(100000))));
         end else if (pick < 90) begin
            pending_reqs.push_back(jump_req());
         end else if (pick < 92) begin
            pending_reqs.push_back(noise_req());
            pending_reqs[$].kind = REQ_HOME;
            wheel_time = 0;
         end else begin
            pending_reqs.push_back(noise_req());
         end
      end
   endtask

   initial begin
      pos_x = 0;
      pos_y = 0;
      head = 0;
      clear_motion();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         tx_idle = p < 2 ? 36 : (p < 4 ? 53 : 0);
         rx_idle = p < 2 ? 53 : (p < 4 ? 36 : 0);
         case (p)
            1: begin
               write_csr(CSR_MODE, 20'd1);
               write_csr(CSR_GEAR, 20'd255);
               write_csr(CSR_TRACK, 20'd655360);
               write_csr(CSR_RADIUS, 20'd65535);
            end
            2: begin
               write_csr(CSR_MODE, 20'd0);
               write_csr(CSR_GEAR, 20'd0);
               write_csr(CSR_TRACK, 20'd0);
               write_csr(CSR_RADIUS, 20'd655);
            end
            3: begin
               write_csr(CSR_MODE, 20'd1);
               write_csr(CSR_GEAR, 20'd1);
               write_csr(CSR_TRACK, 20'd6554);
               write_csr(CSR_RADIUS, 20'($urandom_range(655, 65535)));
            end
            4, 5: begin
               write_csr(CSR_MODE, 20'(p - 4));
               write_csr(CSR_GEAR, 20'($urandom_range(1, 255)));
               write_csr(CSR_TRACK, 20'($urandom_range(6554, 655360)));
               write_csr(CSR_RADIUS, 20'($urandom_range(655, 65535)));
            end
            default: ;
         endcase
         if (p == 0) load_directed();
         load_random();
         drain();
      end
      if (failed) begin
         $display("tb: failure");
      end else begin
         $display("tb: success");
      end
      $finish;
   end

endmodule

`default_nettype wire
